/* src/trl_pkg.sv */
`timescale 1ns / 1ps

package trl_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_DEPTH  = 2'd3;

    // reset values of the surface description
    localparam logic [31:0] RST_FORMAT = 32'd21;
    localparam logic [14:0] RST_WIDTH  = 15'd1;
    localparam logic [14:0] RST_HEIGHT = 15'd1;
    localparam logic [11:0] RST_DEPTH  = 12'd1;

    // entries in the queue between classifier and layout unit
    localparam int QUEUE_DEPTH = 2;

    // four-character code, first character in the low byte
    function automatic logic [31:0] fourcc(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d);
        return {d, c, b, a};
    endfunction

    // numbered surface formats
    localparam logic [31:0] FMT_R8G8B8        = 32'd20;
    localparam logic [31:0] FMT_A8R8G8B8      = 32'd21;
    localparam logic [31:0] FMT_X8R8G8B8      = 32'd22;
    localparam logic [31:0] FMT_R5G6B5        = 32'd23;
    localparam logic [31:0] FMT_X1R5G5B5      = 32'd24;
    localparam logic [31:0] FMT_A1R5G5B5      = 32'd25;
    localparam logic [31:0] FMT_A4R4G4B4      = 32'd26;
    localparam logic [31:0] FMT_R3G3B2        = 32'd27;
    localparam logic [31:0] FMT_A8            = 32'd28;
    localparam logic [31:0] FMT_A8R3G3B2      = 32'd29;
    localparam logic [31:0] FMT_X4R4G4B4      = 32'd30;
    localparam logic [31:0] FMT_A2B10G10R10   = 32'd31;
    localparam logic [31:0] FMT_A8B8G8R8      = 32'd32;
    localparam logic [31:0] FMT_X8B8G8R8      = 32'd33;
    localparam logic [31:0] FMT_G16R16        = 32'd34;
    localparam logic [31:0] FMT_A2R10G10B10   = 32'd35;
    localparam logic [31:0] FMT_A16B16G16R16  = 32'd36;
    localparam logic [31:0] FMT_A8P8          = 32'd40;
    localparam logic [31:0] FMT_P8            = 32'd41;
    localparam logic [31:0] FMT_L8            = 32'd50;
    localparam logic [31:0] FMT_A8L8          = 32'd51;
    localparam logic [31:0] FMT_A4L4          = 32'd52;
    localparam logic [31:0] FMT_V8U8          = 32'd60;
    localparam logic [31:0] FMT_L6V5U5        = 32'd61;
    localparam logic [31:0] FMT_X8L8V8U8      = 32'd62;
    localparam logic [31:0] FMT_Q8W8V8U8      = 32'd63;
    localparam logic [31:0] FMT_V16U16        = 32'd64;
    localparam logic [31:0] FMT_A2W10V10U10   = 32'd67;
    localparam logic [31:0] FMT_D16_LOCKABLE  = 32'd70;
    localparam logic [31:0] FMT_D32           = 32'd71;
    localparam logic [31:0] FMT_D15S1         = 32'd73;
    localparam logic [31:0] FMT_D24S8         = 32'd75;
    localparam logic [31:0] FMT_D24X8         = 32'd77;
    localparam logic [31:0] FMT_D24X4S4       = 32'd79;
    localparam logic [31:0] FMT_D16           = 32'd80;
    localparam logic [31:0] FMT_L16           = 32'd81;
    localparam logic [31:0] FMT_D32F_LOCKABLE = 32'd82;
    localparam logic [31:0] FMT_D24FS8        = 32'd83;
    localparam logic [31:0] FMT_D32_LOCKABLE  = 32'd84;
    localparam logic [31:0] FMT_S8_LOCKABLE   = 32'd85;
    localparam logic [31:0] FMT_Q16W16V16U16  = 32'd110;
    localparam logic [31:0] FMT_R16F          = 32'd111;
    localparam logic [31:0] FMT_G16R16F       = 32'd112;
    localparam logic [31:0] FMT_A16B16G16R16F = 32'd113;
    localparam logic [31:0] FMT_R32F          = 32'd114;
    localparam logic [31:0] FMT_G32R32F       = 32'd115;
    localparam logic [31:0] FMT_A32B32G32R32F = 32'd116;
    localparam logic [31:0] FMT_CXV8U8        = 32'd117;
    localparam logic [31:0] FMT_A1            = 32'd118;
    localparam logic [31:0] FMT_A2B10G10R10XR = 32'd119;

    // four-character formats
    localparam logic [31:0] FCC_DXT1 = fourcc("D", "X", "T", "1");
    localparam logic [31:0] FCC_DXT2 = fourcc("D", "X", "T", "2");
    localparam logic [31:0] FCC_DXT3 = fourcc("D", "X", "T", "3");
    localparam logic [31:0] FCC_DXT4 = fourcc("D", "X", "T", "4");
    localparam logic [31:0] FCC_DXT5 = fourcc("D", "X", "T", "5");
    localparam logic [31:0] FCC_ATI1 = fourcc("A", "T", "I", "1");
    localparam logic [31:0] FCC_ATI2 = fourcc("A", "T", "I", "2");
    localparam logic [31:0] FCC_UYVY = fourcc("U", "Y", "V", "Y");
    localparam logic [31:0] FCC_YUY2 = fourcc("Y", "U", "Y", "2");
    localparam logic [31:0] FCC_RGBG = fourcc("R", "G", "B", "G");
    localparam logic [31:0] FCC_GRGB = fourcc("G", "R", "G", "B");
    localparam logic [31:0] FCC_NV12 = fourcc("N", "V", "1", "2");
    localparam logic [31:0] FCC_YV12 = fourcc("Y", "V", "1", "2");
    localparam logic [31:0] FCC_INTZ = fourcc("I", "N", "T", "Z");
    localparam logic [31:0] FCC_DF24 = fourcc("D", "F", "2", "4");
    localparam logic [31:0] FCC_RAWZ = fourcc("R", "A", "W", "Z");
    localparam logic [31:0] FCC_NULL = fourcc("N", "U", "L", "L");
    localparam logic [31:0] FCC_DF16 = fourcc("D", "F", "1", "6");

    // block layout of a format
    typedef struct packed {
        logic       known;
        logic       one_bit;
        logic       planar;
        logic [1:0] bw_log;
        logic [1:0] bh_log;
        logic [4:0] bytes;
    } fmt_t;

    // classified item handed from the front to the layout unit
    typedef struct packed {
        logic        ok;
        logic        known;
        logic [19:0] pitch;
        logic [15:0] rows;
        logic [14:0] bx0;
        logic [14:0] by0;
        logic [4:0]  bytes;
        logic [11:0] front;
        logic [18:0] row_bytes;
        logic [14:0] row_total;
        logic [11:0] slice_total;
    } entry_t;

    function automatic fmt_t decode_format(input logic [31:0] code);
        fmt_t f;
        f.known   = 1'b1;
        f.one_bit = 1'b0;
        f.planar  = 1'b0;
        f.bw_log  = 2'd0;
        f.bh_log  = 2'd0;
        f.bytes   = 5'd0;
        case (code)
            FMT_R8G8B8: f.bytes = 5'd3;
            FMT_A8R8G8B8, FMT_X8R8G8B8, FMT_A2B10G10R10, FMT_A8B8G8R8, FMT_X8B8G8R8,
            FMT_G16R16, FMT_A2R10G10B10, FMT_X8L8V8U8, FMT_Q8W8V8U8, FMT_V16U16,
            FMT_A2W10V10U10, FMT_D32, FMT_D24S8, FMT_D24X8, FMT_D24X4S4,
            FMT_D32F_LOCKABLE, FMT_D24FS8, FMT_D32_LOCKABLE, FMT_G16R16F, FMT_R32F,
            FMT_A2B10G10R10XR:
                f.bytes = 5'd4;
            FMT_R5G6B5, FMT_X1R5G5B5, FMT_A1R5G5B5, FMT_A4R4G4B4, FMT_A8R3G3B2,
            FMT_X4R4G4B4, FMT_A8P8, FMT_A8L8, FMT_V8U8, FMT_L6V5U5, FMT_D16_LOCKABLE,
            FMT_D15S1, FMT_D16, FMT_L16, FMT_R16F, FMT_CXV8U8:
                f.bytes = 5'd2;
            FMT_R3G3B2, FMT_A8, FMT_P8, FMT_L8, FMT_A4L4, FMT_S8_LOCKABLE:
                f.bytes = 5'd1;
            FMT_A16B16G16R16, FMT_Q16W16V16U16, FMT_A16B16G16R16F, FMT_G32R32F:
                f.bytes = 5'd8;
            FMT_A32B32G32R32F: f.bytes = 5'd16;
            FMT_A1:
            begin
                f.one_bit = 1'b1;
                f.bytes   = 5'd1;
            end
            FCC_DXT1, FCC_ATI1:
            begin
                f.bw_log = 2'd2;
                f.bh_log = 2'd2;
                f.bytes  = 5'd8;
            end
            FCC_DXT2, FCC_DXT3, FCC_DXT4, FCC_DXT5, FCC_ATI2:
            begin
                f.bw_log = 2'd2;
                f.bh_log = 2'd2;
                f.bytes  = 5'd16;
            end
            FCC_UYVY, FCC_YUY2, FCC_RGBG, FCC_GRGB:
            begin
                f.bw_log = 2'd1;
                f.bytes  = 5'd4;
            end
            FCC_NV12, FCC_YV12:
            begin
                f.planar = 1'b1;
                f.bytes  = 5'd1;
            end
            FCC_INTZ, FCC_DF24, FCC_RAWZ, FCC_NULL: f.bytes = 5'd4;
            FCC_DF16: f.bytes = 5'd2;
            default: f.known = 1'b0;
        endcase
        return f;
    endfunction

endpackage

/* src/trl_front.sv */
`timescale 1ns / 1ps

module trl_front #(
    parameter int MAX_DIM   = 16384,
    parameter int MAX_DEPTH = 2048
) (
    input  logic [31:0]          format_code,
    input  logic [14:0]          surface_width,
    input  logic [14:0]          surface_height,
    input  logic [11:0]          surface_depth,
    input  logic [14:0]          left_edge,
    input  logic [14:0]          right_edge,
    input  logic [14:0]          top_edge,
    input  logic [14:0]          bottom_edge,
    input  logic [11:0]          front_edge,
    input  logic [11:0]          back_edge,
    output trl_pkg::entry_t      entry
);
    import trl_pkg::*;

    localparam logic [16:0] DIM_LIM   = 17'(MAX_DIM);
    localparam logic [16:0] DEPTH_LIM = 17'(MAX_DEPTH);

    fmt_t        fmt;
    logic [11:0] depth;
    logic [2:0]  bw_m1;
    logic [2:0]  bh_m1;
    logic        dim_bad;
    logic        range_bad;
    logic        mis_align;
    logic        full_cover;
    logic        whole_only;
    logic        shape_ok;
    logic [14:0] bx0;
    logic [14:0] bx1;
    logic [14:0] by0;
    logic [14:0] by1;
    logic [14:0] width_blocks;
    logic [19:0] pitch;
    logic [15:0] rows;
    logic [19:0] span_bytes;

    // format decode and block masks
    assign fmt   = decode_format(format_code);
    assign depth = (surface_depth == 12'd0) ? 12'd1 : surface_depth;
    assign bw_m1 = 3'((4'd1 << fmt.bw_log) - 4'd1);
    assign bh_m1 = 3'((4'd1 << fmt.bh_log) - 4'd1);

    // bounds checks
    assign dim_bad = ({2'b00, surface_width} > DIM_LIM) || ({2'b00, surface_height} > DIM_LIM)
                     || ({5'd0, depth} > DEPTH_LIM);
    assign range_bad = (left_edge >= right_edge) || (top_edge >= bottom_edge)
                       || (front_edge >= back_edge) || (right_edge > surface_width)
                       || (bottom_edge > surface_height) || (back_edge > depth);

    // alignment to the format's blocks; the far edges may also sit on the surface edge
    assign mis_align = (|(left_edge[2:0] & bw_m1)) || (|(top_edge[2:0] & bh_m1))
                       || ((|(right_edge[2:0] & bw_m1)) && (right_edge != surface_width))
                       || ((|(bottom_edge[2:0] & bh_m1)) && (bottom_edge != surface_height));
    assign full_cover = (left_edge == 15'd0) && (top_edge == 15'd0)
                        && (right_edge == surface_width) && (bottom_edge == surface_height);
    assign whole_only = fmt.planar || fmt.one_bit;
    assign shape_ok   = whole_only ? full_cover : !mis_align;

    // block coordinates of the region
    assign bx0 = left_edge >> fmt.bw_log;
    assign by0 = top_edge >> fmt.bh_log;
    assign bx1 = 15'(({1'b0, right_edge} + {13'd0, bw_m1}) >> fmt.bw_log);
    assign by1 = 15'(({1'b0, bottom_edge} + {13'd0, bh_m1}) >> fmt.bh_log);

    // row pitch and block rows of the surface
    assign width_blocks = 15'(({1'b0, surface_width} + {13'd0, bw_m1}) >> fmt.bw_log);
    always_comb
    begin
        if (fmt.one_bit)
            pitch = 20'(({1'b0, surface_width} + 16'd7) >> 3);
        else
            pitch = {5'd0, width_blocks} * {15'd0, fmt.bytes};
    end

    always_comb
    begin
        if (fmt.planar)
            rows = {1'b0, surface_height} + 16'(({1'b0, surface_height} + 16'd1) >> 1);
        else
            rows = 16'(({1'b0, surface_height} + {13'd0, bh_m1}) >> fmt.bh_log);
    end

    assign span_bytes = {5'd0, 15'(bx1 - bx0)} * {15'd0, fmt.bytes};

    // classified item
    always_comb
    begin
        entry.ok          = fmt.known && !dim_bad && !range_bad && shape_ok;
        entry.known       = fmt.known;
        entry.pitch       = pitch;
        entry.rows        = rows;
        entry.bx0         = bx0;
        entry.by0         = by0;
        entry.bytes       = fmt.bytes;
        entry.front       = front_edge;
        entry.row_bytes   = whole_only ? pitch[18:0] : span_bytes[18:0];
        entry.row_total   = whole_only ? rows[14:0] : 15'(by1 - by0);
        entry.slice_total = back_edge - front_edge;
    end

endmodule

/* src/trl_queue.sv */
`timescale 1ns / 1ps

module trl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  trl_pkg::entry_t push_entry,
    output logic            full,
    output logic            pop,
    output trl_pkg::entry_t pop_entry
);
    import trl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // the layout unit never stalls, so the queue drains whenever it holds an item
    assign full      = (count_reg == FULL_CNT);
    assign pop       = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* src/trl_back.sv */
`timescale 1ns / 1ps

module trl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  trl_pkg::entry_t entry,
    output logic            done,
    output logic            region_ok,
    output logic            format_known,
    output logic [43:0]     byte_offset,
    output logic [18:0]     row_pitch,
    output logic [32:0]     slice_pitch,
    output logic [18:0]     row_bytes,
    output logic [14:0]     row_total,
    output logic [11:0]     slice_total
);
    import trl_pkg::*;

    logic        s1_valid_reg;
    logic        s1_ok_reg;
    logic        s1_known_reg;
    logic [35:0] s1_spitch_reg;
    logic [34:0] s1_yoff_reg;
    logic [19:0] s1_xoff_reg;
    logic [11:0] s1_front_reg;
    logic [19:0] s1_pitch_reg;
    logic [18:0] s1_row_bytes_reg;
    logic [14:0] s1_row_total_reg;
    logic [11:0] s1_slice_total_reg;
    logic [47:0] offset_sum;

    logic        done_reg;
    logic        ok_reg;
    logic        known_reg;
    logic [43:0] offset_reg;
    logic [18:0] pitch_reg;
    logic [32:0] spitch_reg;
    logic [18:0] row_bytes_reg;
    logic [14:0] row_total_reg;
    logic [11:0] slice_total_reg;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            done_reg     <= s1_valid_reg;
        end
    end

    // stage 1: slice pitch and row and column offsets
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_ok_reg          <= entry.ok;
            s1_known_reg       <= entry.known;
            s1_spitch_reg      <= {16'd0, entry.pitch} * {20'd0, entry.rows};
            s1_yoff_reg        <= {15'd0, entry.pitch} * {20'd0, entry.by0};
            s1_xoff_reg        <= {5'd0, entry.bx0} * {15'd0, entry.bytes};
            s1_front_reg       <= entry.front;
            s1_pitch_reg       <= entry.pitch;
            s1_row_bytes_reg   <= entry.row_bytes;
            s1_row_total_reg   <= entry.row_total;
            s1_slice_total_reg <= entry.slice_total;
        end
    end

    // stage 2: slice offset plus row and column offsets
    assign offset_sum = {12'd0, s1_spitch_reg} * {36'd0, s1_front_reg}
                        + {13'd0, s1_yoff_reg} + {28'd0, s1_xoff_reg};

    // result register, numeric fields cleared on a failed region
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            ok_reg          <= s1_ok_reg;
            known_reg       <= s1_known_reg;
            offset_reg      <= s1_ok_reg ? offset_sum[43:0] : 44'd0;
            pitch_reg       <= s1_ok_reg ? s1_pitch_reg[18:0] : 19'd0;
            spitch_reg      <= s1_ok_reg ? s1_spitch_reg[32:0] : 33'd0;
            row_bytes_reg   <= s1_ok_reg ? s1_row_bytes_reg : 19'd0;
            row_total_reg   <= s1_ok_reg ? s1_row_total_reg : 15'd0;
            slice_total_reg <= s1_ok_reg ? s1_slice_total_reg : 12'd0;
        end
    end

    assign done         = done_reg;
    assign region_ok    = ok_reg;
    assign format_known = known_reg;
    assign byte_offset  = offset_reg;
    assign row_pitch    = pitch_reg;
    assign slice_pitch  = spitch_reg;
    assign row_bytes    = row_bytes_reg;
    assign row_total    = row_total_reg;
    assign slice_total  = slice_total_reg;

endmodule

/* src/texture_region_layout.sv */
`timescale 1ns / 1ps

// channel   | handshake              | payload
// ----------+------------------------+-----------------------------------------------
// region in | start / busy           | left, right, top, bottom, front, back edges
// result    | done, high per result  | region_ok, format_known, offset, pitches, totals
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one region per cycle sustained; an accepted region passes the queue write, slice pitch
// multiply and offset multiply-add registers in that order, and done rises with the result
// asynchronous active-low reset clears control state and loads the default surface
// busy rises only when the two-entry queue is full, which never happens since the layout
// unit drains one item every cycle; results are never held off
// config writes are always taken; the user must write only while no region is in flight, unchecked by the block

module texture_region_layout #(
    parameter int MAX_DIM   = 16384,
    parameter int MAX_DEPTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [14:0] left_edge,
    input  logic [14:0] right_edge,
    input  logic [14:0] top_edge,
    input  logic [14:0] bottom_edge,
    input  logic [11:0] front_edge,
    input  logic [11:0] back_edge,
    output logic        done,
    output logic        region_ok,
    output logic        format_known,
    output logic [43:0] byte_offset,
    output logic [18:0] row_pitch,
    output logic [32:0] slice_pitch,
    output logic [18:0] row_bytes,
    output logic [14:0] row_total,
    output logic [11:0] slice_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import trl_pkg::*;

    logic [31:0] format_reg;
    logic [14:0] width_reg;
    logic [14:0] height_reg;
    logic [11:0] depth_reg;
    entry_t      front_entry;
    entry_t      back_entry;
    logic        q_full;
    logic        q_pop;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign accept    = start && !q_full;

    // surface description registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= RST_FORMAT;
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            depth_reg  <= RST_DEPTH;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FORMAT: format_reg <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[14:0];
                REG_HEIGHT: height_reg <= cfg_data[14:0];
                REG_DEPTH:  depth_reg  <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // classifier
    trl_front #(
        .MAX_DIM   (MAX_DIM),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .format_code    (format_reg),
        .surface_width  (width_reg),
        .surface_height (height_reg),
        .surface_depth  (depth_reg),
        .left_edge      (left_edge),
        .right_edge     (right_edge),
        .top_edge       (top_edge),
        .bottom_edge    (bottom_edge),
        .front_edge     (front_edge),
        .back_edge      (back_edge),
        .entry          (front_entry)
    );

    // queue between classifier and layout unit
    trl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (back_entry)
    );

    // layout unit
    trl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (q_pop),
        .entry        (back_entry),
        .done         (done),
        .region_ok    (region_ok),
        .format_known (format_known),
        .byte_offset  (byte_offset),
        .row_pitch    (row_pitch),
        .slice_pitch  (slice_pitch),
        .row_bytes    (row_bytes),
        .row_total    (row_total),
        .slice_total  (slice_total)
    );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import trl_pkg::*;

    localparam int SURF_MAX_DIM   = 16384;
    localparam int SURF_MAX_DEPTH = 2048;
    localparam int PIPE_LAT       = 3;
    localparam int FMT_POOL_N     = 68;
    localparam int DIR_ROWS       = 25;
    localparam int RAND_PHASES    = 20;
    localparam int PHASE_ITEMS    = 30;
    localparam int IDLE_PCT       = 28;

    // codes that no format decodes to
    localparam logic [31:0] FMT_UNKNOWN_LO = 32'h0000_0000;
    localparam logic [31:0] FMT_UNKNOWN_HI = 32'hFFFF_FFFF;

    // surface description as held by the four registers
    typedef struct packed {
        logic [31:0] fmt;
        logic [14:0] w;
        logic [14:0] h;
        logic [11:0] d;
    } surface_t;

    // one box region: x/y/z start inclusive, end exclusive
    typedef struct packed {
        logic [14:0] x0;
        logic [14:0] x1;
        logic [14:0] y0;
        logic [14:0] y1;
        logic [11:0] z0;
        logic [11:0] z1;
    } region_t;

    typedef struct packed {
        logic        ok;
        logic        known;
        logic [43:0] offset;
        logic [18:0] pitch;
        logic [32:0] spitch;
        logic [18:0] rbytes;
        logic [14:0] rows;
        logic [11:0] slices;
    } layout_t;

    typedef struct packed {
        surface_t surf;
        region_t  rg;
        logic     typed;
        layout_t  want;
    } stim_row_t;

    typedef struct {
        bit          known;
        bit          one_bit;
        bit          planar;
        int unsigned bw;
        int unsigned bh;
        int unsigned bytes;
    } fmt_info_t;

    localparam layout_t BAD_FORMAT = '0;
    localparam layout_t BAD_REGION = '{1'b0, 1'b1, 44'd0, 19'd0, 33'd0, 19'd0, 15'd0, 12'd0};
    localparam layout_t UNIT_PIXEL = '{1'b1, 1'b1, 44'd0, 19'd4, 33'd4, 19'd4, 15'd1, 12'd1};

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [14:0] left_edge;
    logic [14:0] right_edge;
    logic [14:0] top_edge;
    logic [14:0] bottom_edge;
    logic [11:0] front_edge;
    logic [11:0] back_edge;
    logic        done;
    logic        region_ok;
    logic        format_known;
    logic [43:0] byte_offset;
    logic [18:0] row_pitch;
    logic [32:0] slice_pitch;
    logic [18:0] row_bytes;
    logic [14:0] row_total;
    logic [11:0] slice_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    layout_t     layout_q[$];
    surface_t    cur_surf;
    logic [31:0] fmt_pool [0:FMT_POOL_N-1];
    stim_row_t   stim_tab [0:DIR_ROWS-1];
    bit          idle_on;
    int          regions_sent;
    int          layouts_checked;
    int          settings_used;
    int          mismatches;

    texture_region_layout u_top (.*);

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // block layout of a format code
    function automatic fmt_info_t layout_of(input logic [31:0] code);
        fmt_info_t f;
        f.known   = 1'b1;
        f.one_bit = 1'b0;
        f.planar  = 1'b0;
        f.bw      = 1;
        f.bh      = 1;
        f.bytes   = 0;
        case (code)
            FMT_R8G8B8: f.bytes = 3;
            FMT_A8R8G8B8, FMT_X8R8G8B8, FMT_A2B10G10R10, FMT_A8B8G8R8, FMT_X8B8G8R8,
            FMT_G16R16, FMT_A2R10G10B10, FMT_X8L8V8U8, FMT_Q8W8V8U8, FMT_V16U16,
            FMT_A2W10V10U10, FMT_D32, FMT_D24S8, FMT_D24X8, FMT_D24X4S4,
            FMT_D32F_LOCKABLE, FMT_D24FS8, FMT_D32_LOCKABLE, FMT_G16R16F, FMT_R32F,
            FMT_A2B10G10R10XR, FCC_INTZ, FCC_DF24, FCC_RAWZ, FCC_NULL:
                f.bytes = 4;
            FMT_R5G6B5, FMT_X1R5G5B5, FMT_A1R5G5B5, FMT_A4R4G4B4, FMT_A8R3G3B2,
            FMT_X4R4G4B4, FMT_A8P8, FMT_A8L8, FMT_V8U8, FMT_L6V5U5, FMT_D16_LOCKABLE,
            FMT_D15S1, FMT_D16, FMT_L16, FMT_R16F, FMT_CXV8U8, FCC_DF16:
                f.bytes = 2;
            FMT_R3G3B2, FMT_A8, FMT_P8, FMT_L8, FMT_A4L4, FMT_S8_LOCKABLE:
                f.bytes = 1;
            FMT_A16B16G16R16, FMT_Q16W16V16U16, FMT_A16B16G16R16F, FMT_G32R32F:
                f.bytes = 8;
            FMT_A32B32G32R32F:
                f.bytes = 16;
            FMT_A1:
            begin
                f.one_bit = 1'b1;
                f.bytes   = 1;
            end
            FCC_DXT1, FCC_ATI1:
            begin
                f.bw    = 4;
                f.bh    = 4;
                f.bytes = 8;
            end
            FCC_DXT2, FCC_DXT3, FCC_DXT4, FCC_DXT5, FCC_ATI2:
            begin
                f.bw    = 4;
                f.bh    = 4;
                f.bytes = 16;
            end
            FCC_UYVY, FCC_YUY2, FCC_RGBG, FCC_GRGB:
            begin
                f.bw    = 2;
                f.bytes = 4;
            end
            FCC_NV12, FCC_YV12:
            begin
                f.planar = 1'b1;
                f.bytes  = 1;
            end
            default: f.known = 1'b0;
        endcase
        return f;
    endfunction

    // expected layout of one region on the given surface
    function automatic layout_t predict_layout(input surface_t s, input region_t r);
        fmt_info_t       f;
        layout_t         o;
        longint unsigned w, h, d, pitch, rows, spitch, off, rb, rt, bx0, bx1, by0, by1;
        bit              ok;
        f       = layout_of(s.fmt);
        o       = '0;
        o.known = f.known;
        w       = s.w;
        h       = s.h;
        d       = (s.d == 0) ? 1 : s.d;
        ok      = f.known;
        if (w > SURF_MAX_DIM || h > SURF_MAX_DIM || d > SURF_MAX_DEPTH)
            ok = 1'b0;
        if (r.x0 >= r.x1 || r.y0 >= r.y1 || r.z0 >= r.z1 || r.x1 > w || r.y1 > h || r.z1 > d)
            ok = 1'b0;
        if (!ok)
            return o;

        pitch  = f.one_bit ? (w + 7) / 8 : ((w + f.bw - 1) / f.bw) * f.bytes;
        rows   = f.planar ? h + (h + 1) / 2 : (h + f.bh - 1) / f.bh;
        spitch = pitch * rows;

        if (f.planar || f.one_bit)
        begin
            // only whole planes
            if (r.x0 != 0 || r.y0 != 0 || r.x1 != w || r.y1 != h)
                return o;
            off = spitch * r.z0;
            rb  = pitch;
            rt  = rows;
        end
        else
        begin
            // starts on a block, ends on a block or at the surface edge
            if (r.x0 % f.bw != 0 || (r.x1 % f.bw != 0 && r.x1 != w))
                return o;
            if (r.y0 % f.bh != 0 || (r.y1 % f.bh != 0 && r.y1 != h))
                return o;
            bx0 = r.x0 / f.bw;
            bx1 = (r.x1 + f.bw - 1) / f.bw;
            by0 = r.y0 / f.bh;
            by1 = (r.y1 + f.bh - 1) / f.bh;
            off = spitch * r.z0 + by0 * pitch + bx0 * f.bytes;
            rb  = (bx1 - bx0) * f.bytes;
            rt  = by1 - by0;
        end

        o.ok     = 1'b1;
        o.offset = off[43:0];
        o.pitch  = pitch[18:0];
        o.spitch = spitch[32:0];
        o.rbytes = rb[18:0];
        o.rows   = rt[14:0];
        o.slices = r.z1 - r.z0;
        return o;
    endfunction

    // surface size, mostly small, sometimes at or past the limit
    function automatic logic [14:0] pick_dim();
        int k;
        k = $urandom_range(99);
        if (k < 70)
            return 15'($urandom_range(1, 40));
        else if (k < 80)
            return 15'($urandom_range(41, 300));
        else if (k < 88)
            return 15'(SURF_MAX_DIM);
        else if (k < 92)
            return 15'd0;
        else if (k < 96)
            return 15'($urandom_range(SURF_MAX_DIM + 1, 32767));
        else
            return 15'($urandom_range(SURF_MAX_DIM - 400, SURF_MAX_DIM));
    endfunction

    function automatic surface_t pick_surface();
        surface_t s;
        int       k;
        k = $urandom_range(99);
        if (k < 85)
            s.fmt = fmt_pool[$urandom_range(FMT_POOL_N - 1)];
        else
            s.fmt = $urandom;
        s.w = pick_dim();
        s.h = pick_dim();
        k   = $urandom_range(99);
        if (k < 72)
            s.d = 12'($urandom_range(1, 6));
        else if (k < 80)
            s.d = 12'd0;
        else if (k < 88)
            s.d = 12'(SURF_MAX_DEPTH);
        else if (k < 94)
            s.d = 12'($urandom_range(7, 64));
        else
            s.d = 12'($urandom_range(SURF_MAX_DEPTH + 1, 4095));
        return s;
    endfunction

    // region for the random part: mostly aligned and in bounds, some noise
    function automatic region_t make_region(input surface_t s);
        fmt_info_t f;
        region_t   r;
        int        w, h, d, nb, c0, c1, zlo, pick;
        f    = layout_of(s.fmt);
        w    = s.w;
        h    = s.h;
        d    = (s.d == 0) ? 1 : s.d;
        pick = $urandom_range(99);

        // raw bits on every edge
        if (pick < 6)
        begin
            r = 84'({$urandom, $urandom, $urandom});
            return r;
        end

        // loose edges around the surface bounds
        if (pick < 18 || w == 0 || h == 0)
        begin
            r.x0 = 15'($urandom_range(0, w + 1));
            r.x1 = 15'($urandom_range(0, w + 1));
            r.y0 = 15'($urandom_range(0, h + 1));
            r.y1 = 15'($urandom_range(0, h + 1));
            r.z0 = 12'($urandom_range(0, d + 1));
            r.z1 = 12'($urandom_range(0, d + 1));
            return r;
        end

        if ((f.planar || f.one_bit) && pick < 80)
        begin
            r.x0 = 15'd0;
            r.x1 = 15'(w);
            r.y0 = 15'd0;
            r.y1 = 15'(h);
        end
        else
        begin
            nb   = (w + f.bw - 1) / f.bw;
            c0   = $urandom_range(0, nb - 1);
            c1   = $urandom_range(c0 + 1, nb);
            r.x0 = 15'(c0 * f.bw);
            r.x1 = 15'((c1 * f.bw > w) ? w : c1 * f.bw);
            nb   = (h + f.bh - 1) / f.bh;
            c0   = $urandom_range(0, nb - 1);
            c1   = $urandom_range(c0 + 1, nb);
            r.y0 = 15'(c0 * f.bh);
            r.y1 = 15'((c1 * f.bh > h) ? h : c1 * f.bh);
        end
        zlo  = $urandom_range(0, d - 1);
        r.z0 = 12'(zlo);
        r.z1 = 12'($urandom_range(zlo + 1, d));

        // knock one edge off by one now and then
        if ($urandom_range(99) < 12)
        begin
            case ($urandom_range(5))
                0: r.x0 = r.x0 + 15'd1;
                1: r.x1 = r.x1 - 15'd1;
                2: r.y0 = r.y0 + 15'd1;
                3: r.y1 = r.y1 + 15'd1;
                4: r.z1 = r.z1 + 12'd1;
                default: r.x1 = r.x1 + 15'd1;
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // one register write, entered and left just after a falling edge
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // load a surface, optionally with junk above the register width
    task automatic write_surface(input surface_t s, input bit noisy);
        logic [31:0] junk_w, junk_h, junk_d;
        junk_w = noisy ? $urandom : 32'd0;
        junk_h = noisy ? $urandom : 32'd0;
        junk_d = noisy ? $urandom : 32'd0;
        write_reg(REG_FORMAT, s.fmt);
        write_reg(REG_WIDTH, {junk_w[31:15], s.w});
        write_reg(REG_HEIGHT, {junk_h[31:15], s.h});
        write_reg(REG_DEPTH, {junk_d[31:12], s.d});
        cfg_valid <= 1'b0;
        cur_surf = s;
        settings_used++;
    endtask

    // hold off until every layout has come back, then let the pipe settle
    task automatic drain_layouts();
        start <= 1'b0;
        while (layout_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
        @(negedge clk);
    endtask

    // present one region item and record its layout on acceptance
    task automatic send_region(input region_t rg, input layout_t want);
        int gap;
        if (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        left_edge   <= rg.x0;
        right_edge  <= rg.x1;
        top_edge    <= rg.y0;
        bottom_edge <= rg.y1;
        front_edge  <= rg.z0;
        back_edge   <= rg.z1;
        do
            @(posedge clk);
        while (busy);
        layout_q.push_back(want);
        regions_sent++;
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin : layout_check
        layout_t got;
        layout_t want;
        if (rst_n && done)
        begin
            got = '{region_ok, format_known, byte_offset, row_pitch, slice_pitch,
                    row_bytes, row_total, slice_total};
            if (layout_q.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(got.offset), 64'd0);
            end
            else
            begin
                want = layout_q.pop_front();
                layouts_checked++;
                if (got.ok !== want.ok)
                    report_mismatch("region_ok", 64'(got.ok), 64'(want.ok));
                if (got.known !== want.known)
                    report_mismatch("format_known", 64'(got.known), 64'(want.known));
                if (got.offset !== want.offset)
                    report_mismatch("byte_offset", 64'(got.offset), 64'(want.offset));
                if (got.pitch !== want.pitch)
                    report_mismatch("row_pitch", 64'(got.pitch), 64'(want.pitch));
                if (got.spitch !== want.spitch)
                    report_mismatch("slice_pitch", 64'(got.spitch), 64'(want.spitch));
                if (got.rbytes !== want.rbytes)
                    report_mismatch("row_bytes", 64'(got.rbytes), 64'(want.rbytes));
                if (got.rows !== want.rows)
                    report_mismatch("row_total", 64'(got.rows), 64'(want.rows));
                if (got.slices !== want.slices)
                    report_mismatch("slice_total", 64'(got.slices), 64'(want.slices));
            end
        end
    end

    // stimulus
    initial
    begin
        int       i;
        int       ph;
        int       k;
        region_t  rg;
        surface_t s;

        start           = 1'b0;
        left_edge       = '0;
        right_edge      = '0;
        top_edge        = '0;
        bottom_edge     = '0;
        front_edge      = '0;
        back_edge       = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        idle_on         = 1'b1;
        regions_sent    = 0;
        layouts_checked = 0;
        settings_used   = 1;
        mismatches      = 0;
        cur_surf        = '{RST_FORMAT, RST_WIDTH, RST_HEIGHT, RST_DEPTH};

        fmt_pool = '{FMT_R8G8B8, FMT_A8R8G8B8, FMT_X8R8G8B8, FMT_R5G6B5, FMT_X1R5G5B5,
                     FMT_A1R5G5B5, FMT_A4R4G4B4, FMT_R3G3B2, FMT_A8, FMT_A8R3G3B2,
                     FMT_X4R4G4B4, FMT_A2B10G10R10, FMT_A8B8G8R8, FMT_X8B8G8R8,
                     FMT_G16R16, FMT_A2R10G10B10, FMT_A16B16G16R16, FMT_A8P8, FMT_P8,
                     FMT_L8, FMT_A8L8, FMT_A4L4, FMT_V8U8, FMT_L6V5U5, FMT_X8L8V8U8,
                     FMT_Q8W8V8U8, FMT_V16U16, FMT_A2W10V10U10, FMT_D16_LOCKABLE,
                     FMT_D32, FMT_D15S1, FMT_D24S8, FMT_D24X8, FMT_D24X4S4, FMT_D16,
                     FMT_L16, FMT_D32F_LOCKABLE, FMT_D24FS8, FMT_D32_LOCKABLE,
                     FMT_S8_LOCKABLE, FMT_Q16W16V16U16, FMT_R16F, FMT_G16R16F,
                     FMT_A16B16G16R16F, FMT_R32F, FMT_G32R32F, FMT_A32B32G32R32F,
                     FMT_CXV8U8, FMT_A1, FMT_A2B10G10R10XR,
                     FCC_DXT1, FCC_DXT2, FCC_DXT3, FCC_DXT4, FCC_DXT5, FCC_ATI1,
                     FCC_ATI2, FCC_UYVY, FCC_YUY2, FCC_RGBG, FCC_GRGB, FCC_NV12,
                     FCC_YV12, FCC_INTZ, FCC_DF24, FCC_RAWZ, FCC_NULL, FCC_DF16};

        // directed table: surface, region, typed flag, typed layout
        stim_tab[0]  = '{'{FMT_A8R8G8B8, 15'd1, 15'd1, 12'd1},
                         '{15'd0, 15'd1, 15'd0, 15'd1, 12'd0, 12'd1}, 1'b1, UNIT_PIXEL};
        stim_tab[1]  = '{'{FMT_A8R8G8B8, 15'd1, 15'd1, 12'd1},
                         '{15'd1, 15'd1, 15'd0, 15'd1, 12'd0, 12'd1}, 1'b1, BAD_REGION};
        stim_tab[2]  = '{'{FMT_A8R8G8B8, 15'd1, 15'd1, 12'd1},
                         '{15'd0, 15'd1, 15'd0, 15'd1, 12'd0, 12'd2}, 1'b1, BAD_REGION};
        stim_tab[3]  = '{'{FCC_DXT1, 15'd16, 15'd16, 12'd1},
                         '{15'd4, 15'd12, 15'd4, 15'd8, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[4]  = '{'{FCC_DXT1, 15'd16, 15'd16, 12'd1},
                         '{15'd1, 15'd12, 15'd4, 15'd8, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[5]  = '{'{FCC_DXT5, 15'd10, 15'd10, 12'd3},
                         '{15'd8, 15'd10, 15'd8, 15'd10, 12'd1, 12'd3}, 1'b0, '0};
        stim_tab[6]  = '{'{FCC_DXT5, 15'd10, 15'd10, 12'd3},
                         '{15'd8, 15'd9, 15'd0, 15'd4, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[7]  = '{'{FCC_UYVY, 15'd7, 15'd3, 12'd1},
                         '{15'd2, 15'd7, 15'd0, 15'd3, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[8]  = '{'{FCC_NV12, 15'd16, 15'd9, 12'd4},
                         '{15'd0, 15'd16, 15'd0, 15'd9, 12'd1, 12'd3}, 1'b0, '0};
        stim_tab[9]  = '{'{FCC_NV12, 15'd16, 15'd9, 12'd4},
                         '{15'd0, 15'd8, 15'd0, 15'd9, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[10] = '{'{FMT_A1, 15'd13, 15'd5, 12'd2},
                         '{15'd0, 15'd13, 15'd0, 15'd5, 12'd1, 12'd2}, 1'b0, '0};
        stim_tab[11] = '{'{FMT_A32B32G32R32F, 15'd16384, 15'd16384, 12'd2048},
                         '{15'd16383, 15'd16384, 15'd16383, 15'd16384, 12'd2047, 12'd2048},
                         1'b0, '0};
        stim_tab[12] = '{'{FMT_A32B32G32R32F, 15'd16384, 15'd16384, 12'd2048},
                         '{15'd0, 15'd16385, 15'd0, 15'd1, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[13] = '{'{FMT_R8G8B8, 15'd32767, 15'd1, 12'd1},
                         '{15'd0, 15'd1, 15'd0, 15'd1, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[14] = '{'{FMT_R5G6B5, 15'd5, 15'd5, 12'd0},
                         '{15'd1, 15'd4, 15'd2, 15'd3, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[15] = '{'{FMT_R5G6B5, 15'd5, 15'd5, 12'd0},
                         '{15'd0, 15'd1, 15'd0, 15'd1, 12'd0, 12'd2}, 1'b0, '0};
        stim_tab[16] = '{'{FMT_L8, 15'd8, 15'd8, 12'd4095},
                         '{15'd0, 15'd1, 15'd0, 15'd1, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[17] = '{'{FMT_UNKNOWN_HI, 15'd1, 15'd1, 12'd1},
                         '{15'd0, 15'd1, 15'd0, 15'd1, 12'd0, 12'd1}, 1'b1, BAD_FORMAT};
        stim_tab[18] = '{'{FMT_UNKNOWN_LO, 15'd1, 15'd1, 12'd1},
                         '{15'd0, 15'd1, 15'd0, 15'd1, 12'd0, 12'd1}, 1'b1, BAD_FORMAT};
        stim_tab[19] = '{'{FMT_A16B16G16R16, 15'd0, 15'd4, 12'd1},
                         '{15'd0, 15'd1, 15'd0, 15'd1, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[20] = '{'{FMT_A16B16G16R16, 15'd40, 15'd30, 12'd6},
                         '{15'd3, 15'd17, 15'd5, 15'd9, 12'd2, 12'd5}, 1'b0, '0};
        stim_tab[21] = '{'{FMT_A16B16G16R16, 15'd40, 15'd30, 12'd6},
                         '{15'd0, 15'd40, 15'd9, 15'd9, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[22] = '{'{FMT_A16B16G16R16, 15'd40, 15'd30, 12'd6},
                         '{15'd0, 15'd40, 15'd0, 15'd31, 12'd0, 12'd1}, 1'b0, '0};
        stim_tab[23] = '{'{FMT_A16B16G16R16, 15'd40, 15'd30, 12'd6},
                         '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 12'hFFF, 12'hFFF},
                         1'b0, '0};
        stim_tab[24] = '{'{FCC_ATI2, 15'd16384, 15'd16384, 12'd2048},
                         '{15'd0, 15'd16384, 15'd0, 15'd16384, 12'd0, 12'd2048}, 1'b0, '0};

        // reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows, reloading the surface whenever it changes
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (stim_tab[i].surf != cur_surf)
            begin
                drain_layouts();
                write_surface(stim_tab[i].surf, 1'b0);
            end
            if (stim_tab[i].typed)
                send_region(stim_tab[i].rg, stim_tab[i].want);
            else
                send_region(stim_tab[i].rg, predict_layout(cur_surf, stim_tab[i].rg));
        end

        // random phases, one surface each; a few phases run with no gaps
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            s       = pick_surface();
            idle_on = !(ph >= 6 && ph < 9);
            drain_layouts();
            write_surface(s, 1'b1);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // sender holds off mid-phase until everything is back
                if (ph == 12 && k == PHASE_ITEMS / 2)
                    drain_layouts();
                rg = make_region(cur_surf);
                send_region(rg, predict_layout(cur_surf, rg));
            end
        end

        drain_layouts();

        $display("%0d regions sent over %0d surface settings, %0d layouts checked",
                 regions_sent, settings_used, layouts_checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && layout_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
